[src/lgge_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgge_pkg
// Shared constants, command codes and types for the life grid engine.
// ----------------------------------------------------------------------------
package lgge_pkg;

    // grid geometry
    localparam int GRID_ROWS = 32;
    localparam int GRID_COLS = 32;
    localparam int ROW_W     = $clog2(GRID_ROWS);
    localparam int COL_W     = $clog2(GRID_COLS);

    // transfer field widths
    localparam int CMD_W       = 2;
    localparam int ROW_FIELD_W = 5;
    localparam int COL_FIELD_W = 5;
    localparam int FLIP_W      = 11;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 16;

    localparam int unsigned FLIP_MAX = 2047;
    localparam int FLIP_ACC_W = $clog2(GRID_ROWS * GRID_COLS + 1);

    // flip popcount: groups of eight bits, then a sum over the groups
    localparam int GRP_BITS = 8;
    localparam int NGROUP   = (GRID_COLS + GRP_BITS - 1) / GRP_BITS;
    localparam int GRP_W    = $clog2(GRP_BITS + 1);

    // command codes
    localparam logic [CMD_W-1:0] CMD_TOGGLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STEP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    typedef logic [GRID_COLS-1:0] row_bits_t;

    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] addr;
        row_bits_t        data;
    } mem_wr_t;

endpackage
`default_nettype wire

[src/lgge_row_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgge_row_unit
// Next generation of one row from a three-row window (B3/S23, dead border).
// ----------------------------------------------------------------------------
module lgge_row_unit (
    input  wire  lgge_pkg::row_bits_t above_row,
    input  wire  lgge_pkg::row_bits_t this_row,
    input  wire  lgge_pkg::row_bits_t below_row,
    output logic [lgge_pkg::GRID_COLS-1:0] next_row
);

    logic [lgge_pkg::GRID_COLS+1:0] above_pad;
    logic [lgge_pkg::GRID_COLS+1:0] this_pad;
    logic [lgge_pkg::GRID_COLS+1:0] below_pad;

    // one dead column on each side
    assign above_pad = {1'b0, above_row, 1'b0};
    assign this_pad  = {1'b0, this_row,  1'b0};
    assign below_pad = {1'b0, below_row, 1'b0};

    always_comb begin
        logic [3:0] n;
        next_row = '0;
        for (int c = 0; c < lgge_pkg::GRID_COLS; c++) begin
            n = 4'(above_pad[c]) + 4'(above_pad[c+1]) + 4'(above_pad[c+2])
              + 4'(this_pad[c])                       + 4'(this_pad[c+2])
              + 4'(below_pad[c]) + 4'(below_pad[c+1]) + 4'(below_pad[c+2]);
            next_row[c] = (n == 4'd3) || (this_row[c] && (n == 4'd2));
        end
    end

endmodule
`default_nettype wire

[src/lgge_grid_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgge_grid_mem
// Cell grid store, one row per entry; per-row valid bits give dead at reset.
// ----------------------------------------------------------------------------
module lgge_grid_mem (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire  lgge_pkg::mem_wr_t          wr,
    input  wire  [lgge_pkg::ROW_W-1:0]       rd_addr,
    output logic [lgge_pkg::GRID_COLS-1:0]   rd_row
);

    lgge_pkg::row_bits_t            mem_reg [lgge_pkg::GRID_ROWS];
    logic [lgge_pkg::GRID_ROWS-1:0] vld_reg;
    lgge_pkg::row_bits_t            rd_data_reg;
    logic                           rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem_reg[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                vld_reg[wr.addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    // unwritten rows read as dead
    assign rd_row = rd_vld_reg ? rd_data_reg : '0;

endmodule
`default_nettype wire

[src/life_grid_generation_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// life_grid_generation_engine
// Bounded Game of Life grid (B3/S23) with toggle, step and read commands.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata fields (low bit up)                 | per transfer
//  --------+-----+-------------------------------------------+----------------
//  s_      | in  | command[1:0] row[6:2] col[11:7]           | one command
//  m_      | out | cell_alive[0] flip_count[11:1] stable[12] | one result
//
//  Toggle and read do one grid memory read, then the cell update. In a step,
//  the row unit sweeps the grid one row per cycle through a three-row window,
//  and the flip popcount trails by two stages.
//  s_tready is high only while the sequencer is idle; one result may wait in
//  the output register while the next command is taken.
//  Synchronous active-low reset; the grid reads as all dead after reset
//  through per-row valid bits, so no clearing pass is needed.
//
module life_grid_generation_engine (
    input  wire                               aclk,
    input  wire                               aresetn,
    // command[1:0], row[6:2], col[11:7], zero pad above
    input  wire  [lgge_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // cell_alive[0], flip_count[11:1], stable[12], zero pad above
    output logic [lgge_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tvalid,
    input  wire                               m_tready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CELL,
        ST_PRIME,
        ST_ROW,
        ST_DRAIN_A,
        ST_DRAIN_B,
        ST_DONE
    } state_t;

    // input fields
    logic [lgge_pkg::CMD_W-1:0]       s_command;
    logic [lgge_pkg::ROW_FIELD_W-1:0] s_row;
    logic [lgge_pkg::COL_FIELD_W-1:0] s_col;

    assign s_command = s_tdata[1:0];
    assign s_row     = s_tdata[6:2];
    assign s_col     = s_tdata[11:7];

    state_t                           state_reg, state_next;
    logic [lgge_pkg::CMD_W-1:0]       cmd_reg, cmd_next;
    logic [lgge_pkg::ROW_FIELD_W-1:0] row_reg, row_next;
    logic [lgge_pkg::COL_FIELD_W-1:0] col_reg, col_next;
    logic                             inside_reg, inside_next;
    lgge_pkg::row_bits_t              above_reg, above_next;
    lgge_pkg::row_bits_t              this_reg, this_next;
    logic [lgge_pkg::ROW_W-1:0]       wr_idx_reg, wr_idx_next;
    lgge_pkg::row_bits_t              diff_reg, diff_next;
    logic                             diff_vld_reg, diff_vld_next;
    logic [lgge_pkg::GRP_W-1:0]       grp_reg [lgge_pkg::NGROUP];
    logic [lgge_pkg::GRP_W-1:0]       grp_next [lgge_pkg::NGROUP];
    logic                             grp_vld_reg, grp_vld_next;
    logic [lgge_pkg::FLIP_ACC_W-1:0]  flip_acc_reg, flip_acc_next;
    logic                             cell_res_reg, cell_res_next;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [lgge_pkg::M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    lgge_pkg::mem_wr_t                mem_wr;
    logic [lgge_pkg::ROW_W-1:0]       rd_addr;
    lgge_pkg::row_bits_t              rd_row;
    lgge_pkg::row_bits_t              below_row;
    lgge_pkg::row_bits_t              new_row;

    lgge_grid_mem u_grid_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (mem_wr),
        .rd_addr (rd_addr),
        .rd_row  (rd_row)
    );

    // below the last row lies the dead border
    assign below_row = (wr_idx_reg == lgge_pkg::ROW_W'(lgge_pkg::GRID_ROWS - 1)) ?
                       '0 : rd_row;

    lgge_row_unit u_row_unit (
        .above_row (above_reg),
        .this_row  (this_reg),
        .below_row (below_row),
        .next_row  (new_row)
    );

    // flip popcount, stage one: per-group counts of the changed bits
    always_comb begin
        logic [lgge_pkg::NGROUP*lgge_pkg::GRP_BITS-1:0] diff_pad;
        diff_pad = (lgge_pkg::NGROUP * lgge_pkg::GRP_BITS)'(diff_reg);
        for (int g = 0; g < lgge_pkg::NGROUP; g++) begin
            grp_next[g] = '0;
            for (int b = 0; b < lgge_pkg::GRP_BITS; b++) begin
                grp_next[g] = grp_next[g]
                            + lgge_pkg::GRP_W'(diff_pad[g*lgge_pkg::GRP_BITS+b]);
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        logic [lgge_pkg::FLIP_ACC_W-1:0] grp_sum;
        logic [lgge_pkg::GRID_COLS-1:0]  mask;
        logic                            cur_bit;
        logic [lgge_pkg::FLIP_W-1:0]     flip_out;

        state_next    = state_reg;
        cmd_next      = cmd_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        inside_next   = inside_reg;
        above_next    = above_reg;
        this_next     = this_reg;
        wr_idx_next   = wr_idx_reg;
        diff_next     = diff_reg;
        cell_res_next = cell_res_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        mem_wr        = '0;
        rd_addr       = '0;

        // popcount pipeline runs behind the row sweep
        diff_vld_next = 1'b0;
        grp_vld_next  = diff_vld_reg;
        grp_sum       = '0;
        for (int g = 0; g < lgge_pkg::NGROUP; g++) begin
            grp_sum = grp_sum + lgge_pkg::FLIP_ACC_W'(grp_reg[g]);
        end
        flip_acc_next = grp_vld_reg ? flip_acc_reg + grp_sum : flip_acc_reg;

        mask                           = '0;
        mask[lgge_pkg::COL_W'(col_reg)] = 1'b1;
        cur_bit = inside_reg && rd_row[lgge_pkg::COL_W'(col_reg)];

        if (32'(flip_acc_reg) > lgge_pkg::FLIP_MAX) begin
            flip_out = lgge_pkg::FLIP_W'(lgge_pkg::FLIP_MAX);
        end else begin
            flip_out = lgge_pkg::FLIP_W'(flip_acc_reg);
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                // step starts its sweep at row 0
                rd_addr = (s_command == lgge_pkg::CMD_STEP) ?
                          '0 : lgge_pkg::ROW_W'(s_row);
                if (s_tvalid) begin
                    cmd_next      = s_command;
                    row_next      = s_row;
                    col_next      = s_col;
                    inside_next   = (32'(s_row) < lgge_pkg::GRID_ROWS) &&
                                    (32'(s_col) < lgge_pkg::GRID_COLS);
                    flip_acc_next = '0;
                    cell_res_next = 1'b0;
                    unique case (s_command) inside
                        lgge_pkg::CMD_TOGGLE,
                        lgge_pkg::CMD_READ: state_next = ST_CELL;
                        lgge_pkg::CMD_STEP: state_next = ST_PRIME;
                        default:            state_next = ST_DONE;
                    endcase
                end
            end
            ST_CELL: begin
                if ((cmd_reg == lgge_pkg::CMD_TOGGLE) && inside_reg) begin
                    mem_wr.en     = 1'b1;
                    mem_wr.addr   = lgge_pkg::ROW_W'(row_reg);
                    mem_wr.data   = rd_row ^ mask;
                    cell_res_next = !cur_bit;
                end else begin
                    cell_res_next = cur_bit;
                end
                state_next = ST_DONE;
            end
            ST_PRIME: begin
                above_next  = '0;
                this_next   = rd_row;
                wr_idx_next = '0;
                rd_addr     = lgge_pkg::ROW_W'(1);
                state_next  = ST_ROW;
            end
            ST_ROW: begin
                // old rows stay in the window, so the new row goes back in place
                mem_wr.en     = 1'b1;
                mem_wr.addr   = wr_idx_reg;
                mem_wr.data   = new_row;
                diff_next     = new_row ^ this_reg;
                diff_vld_next = 1'b1;
                above_next    = this_reg;
                this_next     = below_row;
                rd_addr       = lgge_pkg::ROW_W'(32'(wr_idx_reg) + 2);
                if (wr_idx_reg == lgge_pkg::ROW_W'(lgge_pkg::GRID_ROWS - 1)) begin
                    state_next = ST_DRAIN_A;
                end else begin
                    wr_idx_next = wr_idx_reg + 1'b1;
                end
            end
            ST_DRAIN_A: begin
                state_next = ST_DRAIN_B;
            end
            ST_DRAIN_B: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    if (cmd_reg == lgge_pkg::CMD_STEP) begin
                        m_tdata_next[11:1] = flip_out;
                        m_tdata_next[12]   = (flip_acc_reg == '0);
                    end else begin
                        m_tdata_next[0] = cell_res_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            diff_vld_reg <= 1'b0;
            grp_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            diff_vld_reg <= diff_vld_next;
            grp_vld_reg  <= grp_vld_next;
        end
        cmd_reg      <= cmd_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        inside_reg   <= inside_next;
        above_reg    <= above_next;
        this_reg     <= this_next;
        wr_idx_reg   <= wr_idx_next;
        diff_reg     <= diff_next;
        grp_reg      <= grp_next;
        flip_acc_reg <= flip_acc_next;
        cell_res_reg <= cell_res_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

[src/lgge_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgge_port_checks
// Port-level checks on the life grid engine, bound to the top level.
// ----------------------------------------------------------------------------
module lgge_port_checks (
    input wire                             aclk,
    input wire                             aresetn,
    input wire                             s_tvalid,
    input wire                             s_tready,
    input wire [lgge_pkg::M_TDATA_W-1:0]   m_tdata,
    input wire                             m_tvalid,
    input wire                             m_tready
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a command is never followed by another in the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready high right after a command transfer");

    // stable flag only with a zero flip count
    a_stable_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[12] |-> (m_tdata[11:1] == 11'd0))
        else $error("stable with nonzero flip count");

    // a cell value and a flip count never share a result
    a_cell_or_flip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> (m_tdata[11:1] == 11'd0) && !m_tdata[12])
        else $error("cell result carries step fields");

endmodule

bind life_grid_generation_engine lgge_port_checks u_lgge_port_checks (.*);
`default_nettype wire
